// ===== src/rtsr_pkg.sv =====
`timescale 1ns / 1ps

package rtsr_pkg;

   // Field widths
   localparam int NUM_W  = 62;
   localparam int TIME_W = 64;
   localparam int CNT_W  = 6;
   localparam int OFS_W  = 6;
   localparam int EST_W  = 8;

   // Ring depth default
   localparam int DEPTH_DEFAULT = 64;

   // Function codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_FETCH = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [NUM_W-1:0]  pkt_num;
      logic [TIME_W-1:0] rx_stamp;
      logic [OFS_W-1:0]  fetch_offset;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic              fetch_ok;
      logic [NUM_W-1:0]  fetched_pkt_num;
      logic [TIME_W-1:0] fetched_time;
      logic [CNT_W-1:0]  entry_count;
      logic [EST_W-1:0]  estimate_bytes;
   } rsp_type;

   // Per-item status from the ring control to the output stage
   typedef struct packed {
      logic             accepted;
      logic             fetch_ok;
      logic             is_fetch;
      logic [CNT_W-1:0] entry_count;
      logic [EST_W-1:0] estimate_bytes;
   } meta_type;

endpackage

// ===== src/rtsr_store.sv =====
`timescale 1ns / 1ps

module rtsr_store #(
   parameter int DEPTH = rtsr_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [rtsr_pkg::NUM_W-1:0]  wr_num,
   input  logic [rtsr_pkg::TIME_W-1:0] wr_time,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [rtsr_pkg::NUM_W-1:0]  rd_num,
   output logic [rtsr_pkg::TIME_W-1:0] rd_time
);
   import rtsr_pkg::*;

   logic [NUM_W-1:0]  num_mem  [DEPTH];
   logic [TIME_W-1:0] time_mem [DEPTH];
   logic [NUM_W-1:0]  rd_num_ff;
   logic [TIME_W-1:0] rd_time_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         num_mem[wr_addr]  <= wr_num;
         time_mem[wr_addr] <= wr_time;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_num_ff  <= num_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   assign rd_num  = rd_num_ff;
   assign rd_time = rd_time_ff;

endmodule

// ===== src/rtsr_ctrl.sv =====
`timescale 1ns / 1ps

module rtsr_ctrl #(
   parameter int DEPTH = rtsr_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  rtsr_pkg::req_type        req,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   output rtsr_pkg::meta_type       meta
);
   import rtsr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int MC_W  = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic             first_pending_ff, first_pending_in;
   logic [NUM_W-1:0] expected_ff, expected_in;
   logic [DEPTH-1:0] marks_ff, marks_in;
   logic [MC_W-1:0]  mark_cnt_ff, mark_cnt_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] old_ptr_ff, old_ptr_in;
   logic [PTR_W-1:0] count_ff, count_in;

   logic [NUM_W-1:0] exp_eff;
   logic             is_add;
   logic             is_fetch;
   logic             do_add;
   logic             gap;
   logic             cur_mark;
   logic [PTR_W-1:0] wr_step;
   logic [PTR_W-1:0] old_step;
   logic [SUM_W-1:0] idx_sum;
   logic [SUM_W-1:0] idx_wrap;
   logic             fetch_ok;
   logic [EST_W:0]   est_sum;

   // Decode the item and work out the next ring state
   always_comb begin
      exp_eff  = first_pending_ff ? req.pkt_num : expected_ff;
      is_add   = (req.func == FUNC_ADD);
      is_fetch = (req.func == FUNC_FETCH);
      do_add   = is_add && (req.pkt_num >= exp_eff);
      gap      = (req.pkt_num != exp_eff);
      cur_mark = marks_ff[wr_ptr_ff];
      wr_step  = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      old_step = (old_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : old_ptr_ff + 1'b1;

      first_pending_in = first_pending_ff;
      expected_in      = expected_ff;
      marks_in         = marks_ff;
      mark_cnt_in      = mark_cnt_ff;
      wr_ptr_in        = wr_ptr_ff;
      old_ptr_in       = old_ptr_ff;
      count_in         = count_ff;

      unique case (req.func)
         FUNC_ADD: begin
            first_pending_in = 1'b0;
            if (do_add) begin
               marks_in[wr_ptr_ff] = gap;
               if (gap && !cur_mark) begin
                  mark_cnt_in = mark_cnt_ff + 1'b1;
               end else if (!gap && cur_mark) begin
                  mark_cnt_in = mark_cnt_ff - 1'b1;
               end
               wr_ptr_in   = wr_step;
               expected_in = req.pkt_num + 1'b1;
               if (wr_step == old_ptr_ff) begin
                  old_ptr_in = old_step;
               end
               if (count_ff != PTR_W'(DEPTH - 1)) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         FUNC_CLEAR: begin
            marks_in    = '0;
            mark_cnt_in = '0;
            wr_ptr_in   = '0;
            old_ptr_in  = '0;
            count_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // Fetch address: oldest plus offset, wrapped once
   always_comb begin
      fetch_ok = is_fetch && (req.fetch_offset < CNT_W'(count_ff));
      idx_sum  = {1'b0, CNT_W'(old_ptr_ff)} + {1'b0, req.fetch_offset};
      idx_wrap = (idx_sum >= SUM_W'(DEPTH)) ? idx_sum - SUM_W'(DEPTH) : idx_sum;
   end

   // ACK size estimate: 2 * marks + count + 6 when not empty
   always_comb begin
      est_sum = (EST_W + 1)'({mark_cnt_in, 1'b0}) + (EST_W + 1)'(count_in)
                + (EST_W + 1)'(6);
   end

   assign wr_en   = take && do_add;
   assign wr_addr = wr_ptr_ff;
   assign rd_addr = idx_wrap[PTR_W-1:0];

   always_comb begin
      meta.accepted       = do_add;
      meta.fetch_ok       = fetch_ok;
      meta.is_fetch       = is_fetch;
      meta.entry_count    = CNT_W'(count_in);
      meta.estimate_bytes = (count_in == '0) ? EST_W'(1) : est_sum[EST_W-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         expected_ff      <= '0;
         marks_ff         <= '0;
         mark_cnt_ff      <= '0;
         wr_ptr_ff        <= '0;
         old_ptr_ff       <= '0;
         count_ff         <= '0;
      end else if (take) begin
         first_pending_ff <= first_pending_in;
         expected_ff      <= expected_in;
         marks_ff         <= marks_in;
         mark_cnt_ff      <= mark_cnt_in;
         wr_ptr_ff        <= wr_ptr_in;
         old_ptr_ff       <= old_ptr_in;
         count_ff         <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PTR_W'(DEPTH - 1))
      else $error("entry count above ring capacity");

   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      MC_W'($countones(marks_ff)) == mark_cnt_ff)
      else $error("running mark count out of step with marks");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      take && do_add |=> (count_ff != '0))
      else $error("stored packet left ring empty");
`endif

endmodule

// ===== src/recv_timestamp_ring.sv =====
`timescale 1ns / 1ps

// Ring of received packet numbers and receive times with a gap mark per slot.
// Add, clear and the no-op code need no memory read: a new transfer can be
// taken every cycle while the result register drains. A fetch reads the
// number/time memory, which has a registered read port; the input
// is stalled for the cycle in which the read data returns. The input also
// stalls while a finished result waits on a stalled output. The ring holds at
// most DEPTH-1 entries, and the memory needs no clearing pass after reset.
module recv_timestamp_ring #(
   parameter int DEPTH = rtsr_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rtsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtsr_pkg::rsp_type rsp_data
);
   import rtsr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   logic              take;
   logic              out_free;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_addr;
   meta_type          meta;
   logic [NUM_W-1:0]  rd_num;
   logic [TIME_W-1:0] rd_time;

   logic              pend_valid_ff, pend_valid_in;
   meta_type          pend_meta_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   rtsr_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .req     (req_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .meta    (meta)
   );

   rtsr_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_num  (req_data.pkt_num),
      .wr_time (req_data.rx_stamp),
      .rd_addr (rd_addr),
      .rd_num  (rd_num),
      .rd_time (rd_time)
   );

   // Hold input while a fetch read is in flight or the output is blocked
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff || !out_free;
   assign take      = req_valid && !req_stall;

   // Load the result register: fetches in the cycle after they are taken, with memory data
   always_comb begin
      pend_valid_in = take && meta.is_fetch;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (pend_valid_ff) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.accepted        = 1'b0;
         rsp_data_in.fetch_ok        = pend_meta_ff.fetch_ok;
         rsp_data_in.fetched_pkt_num = pend_meta_ff.fetch_ok ? rd_num : '0;
         rsp_data_in.fetched_time    = pend_meta_ff.fetch_ok ? rd_time : '0;
         rsp_data_in.entry_count     = pend_meta_ff.entry_count;
         rsp_data_in.estimate_bytes  = pend_meta_ff.estimate_bytes;
      end else if (take && !meta.is_fetch) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.accepted        = meta.accepted;
         rsp_data_in.fetch_ok        = 1'b0;
         rsp_data_in.fetched_pkt_num = '0;
         rsp_data_in.fetched_time    = '0;
         rsp_data_in.entry_count     = meta.entry_count;
         rsp_data_in.estimate_bytes  = meta.estimate_bytes;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         pend_meta_ff <= meta;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pend_lands_empty: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !rsp_valid_ff)
      else $error("fetch result would overwrite a waiting result");

   a_fetch_pends: assert property (@(posedge clock) disable iff (reset)
      take && (req_data.func == FUNC_FETCH) |=> pend_valid_ff && rsp_valid_ff == 1'b0)
      else $error("fetch transfer did not start a memory read");

   a_fetch_delivers: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |=> rsp_valid_ff && !pend_valid_ff)
      else $error("pending fetch did not reach the output");

   a_zero_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.fetch_ok |->
         rsp_data_ff.fetched_pkt_num == '0 && rsp_data_ff.fetched_time == '0)
      else $error("failed fetch carries data");
`endif

endmodule
